// ----- src/ezr_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the
// Euler Z-Y-X to rotation matrix block. No dependencies.
package ezr_pkg;

  localparam int ANG_W  = 16;
  localparam int OUT_W  = 16;
  localparam int STEPS  = 24;
  localparam int ZW     = 34;
  localparam int XW     = 34;
  localparam int SCW    = 17;
  localparam int PW     = 35;
  localparam int TW     = 54;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic signed [ZW-1:0] HALF_PI  = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30   = 34'sd3373259426;
  localparam logic signed [XW-1:0] INV_GAIN = 34'sd652032874;
  localparam logic signed [SCW-1:0] ONE_Q15 = 17'sd32768;
  localparam logic signed [OUT_W-1:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [ZW-1:0] zval_t;

  // One beat as it waits in the queue: three reduced angles and their
  // negate flags (index 0 yaw, 1 pitch, 2 roll).
  typedef struct packed {
    zval_t [2:0] z;
    logic  [2:0] neg;
  } angles_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic zval_t atan_q30(input logic [4:0] i);
    zval_t r;
    r = '0;
    unique case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/ezr_front.sv -----
// Front end: takes angle beats, widens them to Q.30 and folds each angle
// into the CORDIC range. Depends on ezr_pkg.
module ezr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ezr_pkg::ANG_W-1:0] yaw_angle,
  input  logic signed [ezr_pkg::ANG_W-1:0] pitch_angle,
  input  logic signed [ezr_pkg::ANG_W-1:0] roll_angle,
  input  ezr_pkg::qstat_t                  qstat,
  output logic                             push,
  output ezr_pkg::angles_t                 push_data
);

  logic                   fr_valid;
  ezr_pkg::angles_t       fr_data;
  ezr_pkg::angles_t       fr_data_next;
  logic                   advance;
  logic [2:0][ezr_pkg::ANG_W-1:0] raw;

  assign raw     = {roll_angle, pitch_angle, yaw_angle};
  assign advance = !fr_valid || !qstat.full;
  assign in_stall = !advance;
  assign push      = fr_valid && !qstat.full;
  assign push_data = fr_data;

  always_comb begin
    ezr_pkg::zval_t w;
    fr_data_next = '0;
    for (int k = 0; k < 3; k++) begin
      w = {raw[k][ezr_pkg::ANG_W-1], raw[k], 17'b0};
      if (w > ezr_pkg::HALF_PI) begin
        fr_data_next.z[k]   = w - ezr_pkg::PI_Q30;
        fr_data_next.neg[k] = 1'b1;
      end else if (w < -ezr_pkg::HALF_PI) begin
        fr_data_next.z[k]   = w + ezr_pkg::PI_Q30;
        fr_data_next.neg[k] = 1'b1;
      end else begin
        fr_data_next.z[k]   = w;
        fr_data_next.neg[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (advance) begin
      fr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      fr_data <= fr_data_next;
    end
  end

endmodule

// ----- src/ezr_fifo.sv -----
// Short queue between the front end and the CORDIC back end.
// Depends on ezr_pkg.
module ezr_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ezr_pkg::angles_t push_data,
  input  logic             pop,
  output ezr_pkg::angles_t pop_data,
  output ezr_pkg::qstat_t  qstat
);

  ezr_pkg::angles_t         mem [ezr_pkg::QDEPTH];
  logic [ezr_pkg::QAW-1:0]  wr_ptr;
  logic [ezr_pkg::QAW-1:0]  rd_ptr;
  logic [ezr_pkg::QAW:0]    count;

  assign qstat.full  = (count == (ezr_pkg::QAW+1)'(ezr_pkg::QDEPTH));
  assign qstat.empty = (count == '0);
  assign pop_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("queue pop while empty");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[ezr_pkg::QAW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

// ----- src/ezr_back.sv -----
// Back end: 24-stage CORDIC for three angles, rounding, products and
// saturation into the output register. Depends on ezr_pkg.
module ezr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  ezr_pkg::qstat_t                  qstat,
  input  ezr_pkg::angles_t                 pop_data,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ezr_pkg::OUT_W-1:0] m00,
  output logic signed [ezr_pkg::OUT_W-1:0] m01,
  output logic signed [ezr_pkg::OUT_W-1:0] m02,
  output logic signed [ezr_pkg::OUT_W-1:0] m10,
  output logic signed [ezr_pkg::OUT_W-1:0] m11,
  output logic signed [ezr_pkg::OUT_W-1:0] m12,
  output logic signed [ezr_pkg::OUT_W-1:0] m20,
  output logic signed [ezr_pkg::OUT_W-1:0] m21,
  output logic signed [ezr_pkg::OUT_W-1:0] m22
);

  localparam int S = ezr_pkg::STEPS;

  logic en;
  logic signed [ezr_pkg::XW-1:0] cx [S][3];
  logic signed [ezr_pkg::XW-1:0] cy [S][3];
  logic signed [ezr_pkg::ZW-1:0] cz [S][3];
  logic [2:0] cneg [S];
  logic [S-1:0] cv;

  // The whole back end moves together; it holds only while a result waits.
  assign en  = !out_valid || !out_stall;
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
    end else if (en) begin
      cv <= {cv[S-2:0], pop};
    end
  end

  for (genvar s = 0; s < S; s++) begin : g_step
    for (genvar k = 0; k < 3; k++) begin : g_ang
      logic signed [ezr_pkg::XW-1:0] xi;
      logic signed [ezr_pkg::XW-1:0] yi;
      logic signed [ezr_pkg::ZW-1:0] zi;
      if (s == 0) begin : g_first
        assign xi = ezr_pkg::INV_GAIN;
        assign yi = '0;
        assign zi = $signed(pop_data.z[k]);
      end else begin : g_rest
        assign xi = cx[s-1][k];
        assign yi = cy[s-1][k];
        assign zi = cz[s-1][k];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (zi >= 0) begin
            cx[s][k] <= xi - (yi >>> s);
            cy[s][k] <= yi + (xi >>> s);
            cz[s][k] <= zi - ezr_pkg::atan_q30(5'(s));
          end else begin
            cx[s][k] <= xi + (yi >>> s);
            cy[s][k] <= yi - (xi >>> s);
            cz[s][k] <= zi + ezr_pkg::atan_q30(5'(s));
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (s == 0) cneg[s] <= pop_data.neg;
        else cneg[s] <= cneg[(s == 0) ? 0 : s-1];
      end
    end
  end

  // Round to Q.15 and clamp; index 0 yaw, 1 pitch, 2 roll.
  logic signed [ezr_pkg::SCW-1:0] sn [3];
  logic signed [ezr_pkg::SCW-1:0] cs [3];
  logic pv;

  function automatic logic signed [ezr_pkg::SCW-1:0] rnd15(
    input logic signed [ezr_pkg::XW-1:0] v, input logic neg);
    logic signed [ezr_pkg::XW:0] t;
    logic signed [ezr_pkg::XW:0] r;
    logic signed [ezr_pkg::SCW-1:0] o;
    t = neg ? -(ezr_pkg::XW+1)'(v) : (ezr_pkg::XW+1)'(v);
    r = (t + 35'sd16384) >>> 15;
    if (r > 35'sd32768) o = ezr_pkg::ONE_Q15;
    else if (r < -35'sd32768) o = -ezr_pkg::ONE_Q15;
    else o = r[ezr_pkg::SCW-1:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cs[k] <= rnd15(cx[S-1][k], cneg[S-1][k]);
        sn[k] <= rnd15(cy[S-1][k], cneg[S-1][k]);
      end
    end
  end

  // Pairwise products.
  logic signed [ezr_pkg::PW-1:0] p_cpcy, p_crsy, p_srsp, p_crsp, p_srsy;
  logic signed [ezr_pkg::PW-1:0] p_cpsy, p_crcy, p_srcy, p_srcp, p_crcp;
  logic signed [ezr_pkg::SCW-1:0] a_cy, a_sy, a_sp;
  logic av;

  always_ff @(posedge clk) begin
    if (en) begin
      p_cpcy <= ezr_pkg::PW'(cs[1] * cs[0]);
      p_crsy <= ezr_pkg::PW'(cs[2] * sn[0]);
      p_srsp <= ezr_pkg::PW'(sn[2] * sn[1]);
      p_crsp <= ezr_pkg::PW'(cs[2] * sn[1]);
      p_srsy <= ezr_pkg::PW'(sn[2] * sn[0]);
      p_cpsy <= ezr_pkg::PW'(cs[1] * sn[0]);
      p_crcy <= ezr_pkg::PW'(cs[2] * cs[0]);
      p_srcy <= ezr_pkg::PW'(sn[2] * cs[0]);
      p_srcp <= ezr_pkg::PW'(sn[2] * cs[1]);
      p_crcp <= ezr_pkg::PW'(cs[2] * cs[1]);
      a_cy   <= cs[0];
      a_sy   <= sn[0];
      a_sp   <= sn[1];
    end
  end

  // Triple products and the Q.45 forms of the pairwise terms.
  logic signed [ezr_pkg::TW-1:0] t01, t02, t11, t12;
  logic signed [ezr_pkg::TW-1:0] q00, q01, q02, q10, q11, q12, q20, q21, q22;

  always_ff @(posedge clk) begin
    if (en) begin
      t01 <= ezr_pkg::TW'(p_srsp * a_cy);
      t02 <= ezr_pkg::TW'(p_crsp * a_cy);
      t11 <= ezr_pkg::TW'(p_srsp * a_sy);
      t12 <= ezr_pkg::TW'(p_crsp * a_sy);
      q00 <= ezr_pkg::TW'(p_cpcy) <<< 15;
      q01 <= ezr_pkg::TW'(p_crsy) <<< 15;
      q02 <= ezr_pkg::TW'(p_srsy) <<< 15;
      q10 <= ezr_pkg::TW'(p_cpsy) <<< 15;
      q11 <= ezr_pkg::TW'(p_crcy) <<< 15;
      q12 <= ezr_pkg::TW'(p_srcy) <<< 15;
      q20 <= -(ezr_pkg::TW'(a_sp) <<< 30);
      q21 <= ezr_pkg::TW'(p_srcp) <<< 15;
      q22 <= ezr_pkg::TW'(p_crcp) <<< 15;
    end
  end

  function automatic logic signed [ezr_pkg::OUT_W-1:0] fin(
    input logic signed [ezr_pkg::TW-1:0] v);
    logic signed [ezr_pkg::TW-1:0] r;
    logic signed [ezr_pkg::OUT_W-1:0] o;
    r = (v + (ezr_pkg::TW'(1) <<< 30)) >>> 31;
    if (r > ezr_pkg::TW'(16384)) o = ezr_pkg::ONE_Q14;
    else if (r < -ezr_pkg::TW'(16384)) o = -ezr_pkg::ONE_Q14;
    else o = r[ezr_pkg::OUT_W-1:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m00 <= fin(q00);
      m01 <= fin(t01 - q01);
      m02 <= fin(t02 + q02);
      m10 <= fin(q10);
      m11 <= fin(t11 + q11);
      m12 <= fin(t12 - q12);
      m20 <= fin(q20);
      m21 <= fin(q21);
      m22 <= fin(q22);
    end
  end

  logic tv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= 1'b0;
      av        <= 1'b0;
      tv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      pv        <= cv[S-1];
      av        <= pv;
      tv        <= av;
      out_valid <= tv;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(m00) && $stable(m22))
    else $error("stalled result changed");
  a_pop_enable: assert property (@(posedge clk) disable iff (rst) pop |-> en)
    else $error("queue popped while back end held");
  a_stage_in: assert property (@(posedge clk) disable iff (rst)
    en |=> cv[0] == $past(pop))
    else $error("first stage valid does not follow pop");
`endif

endmodule

// ----- src/euler_zyx_to_rotation_matrix.sv -----
// Top level of the Z-Y-X Euler angle to rotation matrix block.
// Depends on ezr_pkg, ezr_front, ezr_fifo and ezr_back.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   yaw_angle pitch_angle roll_angle (Q2.13)
//   out      out_valid / out_stall m00 .. m22 (Q1.14)
//
// One beat in and one result out per cycle when the output is not stalled.
// A result reaches the outputs through the front register, the queue, 24 CORDIC
// steps, rounding, two multiply stages and the output register.
// A stalled output holds the whole back end; the four-entry queue and the
// front register keep taking beats until they fill.
// Synchronous reset empties the queue and clears all valid flags.
module euler_zyx_to_rotation_matrix (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ezr_pkg::ANG_W-1:0] yaw_angle,
  input  logic signed [ezr_pkg::ANG_W-1:0] pitch_angle,
  input  logic signed [ezr_pkg::ANG_W-1:0] roll_angle,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ezr_pkg::OUT_W-1:0] m00,
  output logic signed [ezr_pkg::OUT_W-1:0] m01,
  output logic signed [ezr_pkg::OUT_W-1:0] m02,
  output logic signed [ezr_pkg::OUT_W-1:0] m10,
  output logic signed [ezr_pkg::OUT_W-1:0] m11,
  output logic signed [ezr_pkg::OUT_W-1:0] m12,
  output logic signed [ezr_pkg::OUT_W-1:0] m20,
  output logic signed [ezr_pkg::OUT_W-1:0] m21,
  output logic signed [ezr_pkg::OUT_W-1:0] m22
);

  ezr_pkg::qstat_t  qstat;
  ezr_pkg::angles_t push_data;
  ezr_pkg::angles_t pop_data;
  logic             push;
  logic             pop;

  ezr_front u_front (
    .clk, .rst, .in_valid, .in_stall, .yaw_angle, .pitch_angle, .roll_angle,
    .qstat, .push, .push_data
  );

  ezr_fifo u_fifo (
    .clk, .rst, .push, .push_data, .pop, .pop_data, .qstat
  );

  ezr_back u_back (
    .clk, .rst, .qstat, .pop_data, .pop, .out_valid, .out_stall,
    .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22
  );

endmodule

// ----- verif/tb_euler_zyx_to_rotation_matrix.sv -----
// Self-checking testbench for euler_zyx_to_rotation_matrix: a clocked driver and monitor,
// with a bit-exact CORDIC predictor of the nine matrix elements. Depends on ezr_pkg and euler_zyx_to_rotation_matrix.
module tb_euler_zyx_to_rotation_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ezr_pkg::ANG_W-1:0] yaw;
    logic [ezr_pkg::ANG_W-1:0] pitch;
    logic [ezr_pkg::ANG_W-1:0] roll;
  } angle_beat_t;

  typedef logic [8:0][ezr_pkg::OUT_W-1:0] matrix_t;

  localparam longint TB_PI      = 64'sd3373259426;
  localparam longint TB_HALF_PI = 64'sd1686629713;
  localparam longint TB_ONE     = 64'sd32768;
  localparam longint TB_ATAN [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ezr_pkg::ANG_W-1:0] yaw_angle = '0;
  logic signed [ezr_pkg::ANG_W-1:0] pitch_angle = '0;
  logic signed [ezr_pkg::ANG_W-1:0] roll_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ezr_pkg::OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  angle_beat_t pending_angles[$];
  matrix_t     expected_matrices[$];
  int          errors = 0;
  int          beats_sent = 0;
  int          beats_seen = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          hold_cnt = 0;
  bit          held_once = 0;
  bit          drained_once = 0;

  euler_zyx_to_rotation_matrix u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void cordic_sin_cos(input logic [ezr_pkg::ANG_W-1:0] raw,
                                         output longint s, output longint c);
    longint z, x, y, nx;
    bit neg;
    z = longint'($signed(raw)) * 131072;
    x = 652032874;
    y = 0;
    neg = 0;
    // Angles past a quarter turn are folded by half a turn; their sine and cosine are then negated.
    if (z > TB_HALF_PI) begin
      z -= TB_PI;
      neg = 1;
    end else if (z < -TB_HALF_PI) begin
      z += TB_PI;
      neg = 1;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= TB_ATAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += TB_ATAN[i];
      end
      x = nx;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = clamp_mag((x + 16384) >>> 15, TB_ONE);
    s = clamp_mag((y + 16384) >>> 15, TB_ONE);
  endfunction

  function automatic logic [ezr_pkg::OUT_W-1:0] round_element(longint v);
    return ezr_pkg::OUT_W'(clamp_mag((v + 64'sd1073741824) >>> 31, 16384));
  endfunction

  function automatic matrix_t rotation_matrix(angle_beat_t a);
    longint sy, cy, sp, cp, sr, cr;
    matrix_t m;
    cordic_sin_cos(a.yaw, sy, cy);
    cordic_sin_cos(a.pitch, sp, cp);
    cordic_sin_cos(a.roll, sr, cr);
    m[0] = round_element(cp * cy * TB_ONE);
    m[1] = round_element(sr * sp * cy - cr * sy * TB_ONE);
    m[2] = round_element(cr * sp * cy + sr * sy * TB_ONE);
    m[3] = round_element(cp * sy * TB_ONE);
    m[4] = round_element(sr * sp * sy + cr * cy * TB_ONE);
    m[5] = round_element(cr * sp * sy - sr * cy * TB_ONE);
    m[6] = round_element(-sp * TB_ONE * TB_ONE);
    m[7] = round_element(sr * cp * TB_ONE);
    m[8] = round_element(cr * cp * TB_ONE);
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [ezr_pkg::OUT_W-1:0] got,
                                 logic [ezr_pkg::OUT_W-1:0] want);
    errors++;
    $display("mismatch at beat %0d: %s got %0d expected %0d", beats_seen, what,
             $signed(got), $signed(want));
  endtask

  function automatic logic [ezr_pkg::ANG_W-1:0] pick_angle();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return ezr_pkg::ANG_W'($urandom_range(0, 51472) - 25736);
    if (k < 8) return ezr_pkg::ANG_W'($urandom);
    return ezr_pkg::ANG_W'($urandom_range(0, 40) - 20 +
                           (($urandom_range(0, 1) != 0) ? 12868 : -12868));
  endfunction

  initial begin
    logic [ezr_pkg::ANG_W-1:0] edge_vals [14];
    edge_vals = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, 16'sd12869, -16'sd12868,
                  -16'sd12869, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sd6434,
                  16'sd25735, -16'sd25737};
    foreach (edge_vals[i])
      pending_angles.push_back('{edge_vals[i], edge_vals[(i + 3) % 14], edge_vals[(i + 7) % 14]});
    pending_angles.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
    pending_angles.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
    pending_angles.push_back('{16'sd0, 16'sd12868, 16'sd0});
    pending_angles.push_back('{16'sd0, -16'sd12868, 16'sd0});
    for (int n = 0; n < 1750; n++)
      pending_angles.push_back('{pick_angle(), pick_angle(), pick_angle()});
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: a beat that is offered stays put until it is taken.
  always @(posedge clk) begin : drive_angles
    logic nv;
    bit tail;
    nv = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_matrices.push_back(rotation_matrix(pending_angles.pop_front()));
        beats_sent++;
      end
      tail = pending_angles.size() < 150;
      if (in_valid && in_stall) begin
        nv = 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
      end else if (beats_sent == 1000 && !drained_once) begin
        if (expected_matrices.size() == 0) drained_once = 1;
      end else if (pending_angles.size() > 0) begin
        if (!tail && $urandom_range(0, 7) == 0) in_gap = $urandom_range(0, 14);
        else nv = 1'b1;
      end
      if (nv) begin
        yaw_angle   <= pending_angles[0].yaw;
        pitch_angle <= pending_angles[0].pitch;
        roll_angle  <= pending_angles[0].roll;
      end
      in_valid <= nv;
    end
  end

  // A long receiver hold-off, once, so the queue backs up into the input.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
      else if (beats_seen == 400 && !held_once) begin
        held_once <= 1;
        hold_cnt <= 300;
      end
    end
  end

  always @(posedge clk) begin : check_matrices
    matrix_t want, got;
    bit ns;
    ns = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {m00, m01, m02, m10, m11, m12, m20, m21, m22};
        got = {got[0], got[1], got[2], got[3], got[4], got[5], got[6], got[7], got[8]};
        if (expected_matrices.size() == 0) begin
          errors++;
          $display("unexpected result beat %0d", beats_seen);
        end else begin
          want = expected_matrices.pop_front();
          for (int i = 0; i < 9; i++)
            if (got[i] !== want[i])
              report_mismatch($sformatf("m%0d%0d", i / 3, i % 3), got[i], want[i]);
        end
        beats_seen++;
      end
      if (out_gap > 0) begin
        out_gap--;
        ns = 1'b1;
      end else if (pending_angles.size() >= 150 && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 14);
        ns = 1'b1;
      end
      out_stall <= ns || (hold_cnt > 0);
    end
  end

  initial begin
    wait (!rst);
    wait (pending_angles.size() == 0 && !in_valid);
    wait (expected_matrices.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_matrices.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ----- sim.f -----
src/ezr_pkg.sv
src/ezr_front.sv
src/ezr_fifo.sv
src/ezr_back.sv
src/euler_zyx_to_rotation_matrix.sv
verif/tb_euler_zyx_to_rotation_matrix.sv
